FILE: design/tltc_pkg.sv
// ----------------------------------------------------------------------------
// tltc_pkg
// Shared constants, codes and controller/datapath handshake types for the
// tank level and temperature controller.
// ----------------------------------------------------------------------------
package tltc_pkg;

  // default width of the tick counter and the stored press times
  localparam int TICK_WIDTH_DEF = 32;

  // command codes of an input transaction
  localparam logic [2:0] CMD_TICK = 3'd0;
  localparam logic [2:0] CMD_DIST = 3'd1;
  localparam logic [2:0] CMD_TEMP = 3'd2;
  localparam logic [2:0] CMD_DEC  = 3'd3;
  localparam logic [2:0] CMD_INC  = 3'd4;
  localparam logic [2:0] CMD_MODE = 3'd5;

  // status codes of a result transaction
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_REJECT   = 2'd1;
  localparam logic [1:0] ST_DEBOUNCE = 2'd2;
  localparam logic [1:0] ST_BOUND    = 2'd3;

  // configuration register indexes
  localparam logic [2:0] REG_TANK_HEIGHT = 3'd0;
  localparam logic [2:0] REG_NEAR_FULL   = 3'd1;
  localparam logic [2:0] REG_BONUS       = 3'd2;
  localparam logic [2:0] REG_MARGIN      = 3'd3;
  localparam logic [2:0] REG_DEBOUNCE    = 3'd4;
  localparam logic [2:0] REG_TEMP_MIN    = 3'd5;
  localparam logic [2:0] REG_TEMP_MAX    = 3'd6;

  // configuration reset values
  localparam logic [11:0] RST_TANK_HEIGHT = 12'd135;
  localparam logic [11:0] RST_NEAR_FULL   = 12'd35;
  localparam logic [6:0]  RST_BONUS       = 7'd25;
  localparam logic [11:0] RST_MARGIN      = 12'd100;
  localparam logic [15:0] RST_DEBOUNCE    = 16'd200;
  localparam logic [11:0] RST_TEMP_MIN    = 12'hF60;  // -160
  localparam logic [11:0] RST_TEMP_MAX    = 12'd800;

  // limit bounds and steps
  localparam logic [6:0] LEVEL_MIN  = 7'd10;
  localparam logic [6:0] LEVEL_MAX  = 7'd100;
  localparam logic [6:0] LEVEL_STEP = 7'd5;
  localparam logic [5:0] TEMP_LMIN  = 6'd10;
  localparam logic [5:0] TEMP_LMAX  = 6'd50;
  localparam logic [5:0] TEMP_STEP  = 6'd1;
  localparam logic [6:0] PCT_FULL   = 7'd100;

  // quotient bits of the fill division (quotient stays below 128)
  localparam logic [2:0] DIV_LAST_BIT = 3'd6;

  // controller to datapath commands
  typedef struct packed {
    logic       latch;     // capture the input transaction
    logic       eval;      // form numerator and divisor products
    logic       div_step;  // one restoring division step
    logic [2:0] div_bit;   // quotient bit of this step
    logic       commit;    // update state and present the result
  } dp_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic need_div;  // accepted distance sample needs the divider
  } dp_stat_t;

endpackage

FILE: design/tltc_in_if.sv
// ----------------------------------------------------------------------------
// tltc_in_if
// Input event channel: valid/ready handshake with the event payload.
// ----------------------------------------------------------------------------
interface tltc_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         cmd;
  logic [15:0]        distance_mm;
  logic               sample_failed;
  logic signed [11:0] temp_sixteenths;

  modport source (output valid, output cmd, output distance_mm, output sample_failed,
                  output temp_sixteenths, input ready);
  modport sink (input valid, input cmd, input distance_mm, input sample_failed,
                input temp_sixteenths, output ready);
endinterface

FILE: design/tltc_out_if.sv
// ----------------------------------------------------------------------------
// tltc_out_if
// Result channel: valid/ready handshake with the controller outputs.
// ----------------------------------------------------------------------------
interface tltc_out_if;
  logic       valid;
  logic       ready;
  logic       pump_on;
  logic       heater_on;
  logic [6:0] fill_percent;
  logic [6:0] level_setpoint;
  logic [5:0] temp_setpoint;
  logic       adjust_temperature;
  logic [1:0] status;

  modport source (output valid, output pump_on, output heater_on, output fill_percent,
                  output level_setpoint, output temp_setpoint,
                  output adjust_temperature, output status, input ready);
  modport sink (input valid, input pump_on, input heater_on, input fill_percent,
                input level_setpoint, input temp_setpoint,
                input adjust_temperature, input status, output ready);
endinterface

FILE: design/tltc_cfg_if.sv
// ----------------------------------------------------------------------------
// tltc_cfg_if
// Configuration write channel: valid/ready with register index and data.
// ----------------------------------------------------------------------------
interface tltc_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

FILE: design/tltc_ctrl.sv
// ----------------------------------------------------------------------------
// tltc_ctrl
// Sequencer: accepts one transaction, runs the divider when needed, commits
// the result into the output register and holds it until taken.
// ----------------------------------------------------------------------------
module tltc_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  tltc_pkg::dp_stat_t stat,
  output tltc_pkg::dp_cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EVAL = 4'b0010,
    S_DIV  = 4'b0100,
    S_FIN  = 4'b1000
  } state_t;

  state_t     state_r, state_nxt;
  logic [2:0] cnt_r, cnt_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || out_ready;

  // next state and datapath commands
  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    cmd.latch    = 1'b0;
    cmd.eval     = 1'b0;
    cmd.div_step = 1'b0;
    cmd.div_bit  = tltc_pkg::DIV_LAST_BIT - cnt_r;
    cmd.commit   = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd.eval = 1'b1;
        cnt_nxt  = 3'd0;
        state_nxt = stat.need_div ? S_DIV : S_FIN;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 3'd1;
        if (cnt_r == tltc_pkg::DIV_LAST_BIT) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // hold the result valid until the sink takes it
  always_comb begin
    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= 3'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

FILE: design/tltc_dp.sv
// ----------------------------------------------------------------------------
// tltc_dp
// Datapath: configuration registers, controller state, fill percentage
// products with a restoring divider, and the per-event update logic.
// ----------------------------------------------------------------------------
module tltc_dp #(
  parameter int TICK_WIDTH = tltc_pkg::TICK_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  tltc_pkg::dp_cmd_t  cmd,
  output tltc_pkg::dp_stat_t stat,
  // configuration writes
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  // input transaction payload
  input  logic [2:0]         in_cmd,
  input  logic [15:0]        in_distance_mm,
  input  logic               in_sample_failed,
  input  logic signed [11:0] in_temp_sixteenths,
  // result payload
  output logic               pump_on,
  output logic               heater_on,
  output logic [6:0]         fill_percent,
  output logic [6:0]         level_setpoint,
  output logic [5:0]         temp_setpoint,
  output logic               adjust_temperature,
  output logic [1:0]         status
);

  // configuration registers
  logic [11:0] height_r, near_full_r, margin_r;
  logic [6:0]  bonus_r;
  logic [15:0] debounce_r;
  logic [11:0] tmin_r, tmax_r;

  // controller state
  logic [TICK_WIDTH-1:0] tick_r, tick_nxt;
  logic [TICK_WIDTH-1:0] press_r [3];
  logic [6:0]            level_r, level_nxt;
  logic [5:0]            tlim_r, tlim_nxt;
  logic                  mode_r, mode_nxt;
  logic                  pump_r, pump_nxt;
  logic                  heater_r, heater_nxt;
  logic [6:0]            pct_r, pct_nxt;
  logic [1:0]            status_r, status_nxt;

  // captured transaction and divider registers
  logic [2:0]         cmd_r;
  logic [15:0]        dist_r;
  logic               fail_r;
  logic signed [11:0] temp_r;
  logic signed [24:0] num_r;
  logic [24:0]        rem_r;
  logic [18:0]        h100_r;
  logic [6:0]         quo_r;

  // combinational helpers
  logic [11:0]        h_eff;
  logic               reject;
  logic [17:0]        diff;
  logic signed [24:0] diff_ext, num_nxt;
  logic [18:0]        bonus_h;
  logic [24:0]        trial;
  logic [6:0]         pct_calc;
  logic signed [12:0] t_ext, tmin_ext, tmax_ext, tlim16;
  logic [1:0]         btn;
  logic [TICK_WIDTH-1:0] elapsed;
  logic               press_ok, press_we;

  // height of zero counts as one
  assign h_eff  = (height_r == 12'd0) ? 12'd1 : height_r;
  assign reject = ({1'b0, dist_r} > ({5'b0, h_eff} + {5'b0, margin_r}));
  assign stat.need_div = (cmd_r == tltc_pkg::CMD_DIST) && !fail_r && !reject;

  // numerator (h - d) * 100 plus the near-full bonus
  assign diff     = {6'b0, h_eff} - {2'b0, dist_r};
  assign diff_ext = {{7{diff[17]}}, diff};
  assign bonus_h  = 19'(bonus_r) * 19'(h_eff);
  always_comb begin
    num_nxt = diff_ext * 25'sd100;
    if (dist_r < {4'b0, near_full_r}) begin
      num_nxt = num_nxt + $signed({6'b0, bonus_h});
    end
  end

  // divisor aligned to the current quotient bit
  assign trial = {13'b0, h_eff} << cmd.div_bit;

  // clamp the quotient to 0..100
  always_comb begin
    if (num_r <= 25'sd0) begin
      pct_calc = 7'd0;
    end else if (num_r >= $signed({6'b0, h100_r})) begin
      pct_calc = tltc_pkg::PCT_FULL;
    end else begin
      pct_calc = quo_r;
    end
  end

  // temperature comparisons, all signed
  assign t_ext    = {temp_r[11], temp_r};
  assign tmin_ext = {tmin_r[11], tmin_r};
  assign tmax_ext = {tmax_r[11], tmax_r};
  assign tlim16   = $signed({3'b000, tlim_r, 4'b0000});

  // button select and debounce
  always_comb begin
    unique case (cmd_r)
      tltc_pkg::CMD_INC:  btn = 2'd1;
      tltc_pkg::CMD_MODE: btn = 2'd2;
      default:            btn = 2'd0;
    endcase
  end
  assign elapsed  = tick_r - press_r[btn];
  assign press_ok = (elapsed >= TICK_WIDTH'(debounce_r));

  // per-event state update
  always_comb begin
    tick_nxt   = tick_r;
    level_nxt  = level_r;
    tlim_nxt   = tlim_r;
    mode_nxt   = mode_r;
    pump_nxt   = pump_r;
    heater_nxt = heater_r;
    pct_nxt    = pct_r;
    status_nxt = tltc_pkg::ST_OK;
    press_we   = 1'b0;
    unique case (cmd_r)
      tltc_pkg::CMD_TICK: tick_nxt = tick_r + TICK_WIDTH'(1);
      tltc_pkg::CMD_DIST: begin
        if (fail_r) begin
          status_nxt = tltc_pkg::ST_REJECT;
        end else if (reject) begin
          pump_nxt   = 1'b0;
          status_nxt = tltc_pkg::ST_REJECT;
        end else begin
          pct_nxt  = pct_calc;
          pump_nxt = (pct_calc < level_r);
        end
      end
      tltc_pkg::CMD_TEMP: begin
        if ((t_ext < tmin_ext) || (t_ext > tmax_ext)) begin
          status_nxt = tltc_pkg::ST_REJECT;
        end else begin
          heater_nxt = (t_ext < tlim16);
        end
      end
      tltc_pkg::CMD_DEC, tltc_pkg::CMD_INC, tltc_pkg::CMD_MODE: begin
        if (!press_ok) begin
          status_nxt = tltc_pkg::ST_DEBOUNCE;
        end else begin
          press_we = 1'b1;
          if (cmd_r == tltc_pkg::CMD_MODE) begin
            mode_nxt = !mode_r;
          end else if (cmd_r == tltc_pkg::CMD_DEC) begin
            if (mode_r) begin
              if (tlim_r <= tltc_pkg::TEMP_LMIN) status_nxt = tltc_pkg::ST_BOUND;
              else tlim_nxt = tlim_r - tltc_pkg::TEMP_STEP;
            end else begin
              if (level_r <= tltc_pkg::LEVEL_MIN) status_nxt = tltc_pkg::ST_BOUND;
              else level_nxt = level_r - tltc_pkg::LEVEL_STEP;
            end
          end else begin
            if (mode_r) begin
              if (tlim_r >= tltc_pkg::TEMP_LMAX) status_nxt = tltc_pkg::ST_BOUND;
              else tlim_nxt = tlim_r + tltc_pkg::TEMP_STEP;
            end else begin
              if (level_r >= tltc_pkg::LEVEL_MAX) status_nxt = tltc_pkg::ST_BOUND;
              else level_nxt = level_r + tltc_pkg::LEVEL_STEP;
            end
          end
        end
      end
      default: ;
    endcase
  end

  // configuration and controller state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      height_r    <= tltc_pkg::RST_TANK_HEIGHT;
      near_full_r <= tltc_pkg::RST_NEAR_FULL;
      bonus_r     <= tltc_pkg::RST_BONUS;
      margin_r    <= tltc_pkg::RST_MARGIN;
      debounce_r  <= tltc_pkg::RST_DEBOUNCE;
      tmin_r      <= tltc_pkg::RST_TEMP_MIN;
      tmax_r      <= tltc_pkg::RST_TEMP_MAX;
      tick_r      <= '0;
      press_r[0]  <= '0;
      press_r[1]  <= '0;
      press_r[2]  <= '0;
      level_r     <= tltc_pkg::LEVEL_MAX;
      tlim_r      <= tltc_pkg::TEMP_LMIN;
      mode_r      <= 1'b0;
      pump_r      <= 1'b0;
      heater_r    <= 1'b0;
      pct_r       <= 7'd0;
      status_r    <= tltc_pkg::ST_OK;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          tltc_pkg::REG_TANK_HEIGHT: height_r    <= cfg_data[11:0];
          tltc_pkg::REG_NEAR_FULL:   near_full_r <= cfg_data[11:0];
          tltc_pkg::REG_BONUS:       bonus_r     <= cfg_data[6:0];
          tltc_pkg::REG_MARGIN:      margin_r    <= cfg_data[11:0];
          tltc_pkg::REG_DEBOUNCE:    debounce_r  <= cfg_data;
          tltc_pkg::REG_TEMP_MIN:    tmin_r      <= cfg_data[11:0];
          tltc_pkg::REG_TEMP_MAX:    tmax_r      <= cfg_data[11:0];
          default: ;
        endcase
      end
      if (cmd.commit) begin
        tick_r   <= tick_nxt;
        level_r  <= level_nxt;
        tlim_r   <= tlim_nxt;
        mode_r   <= mode_nxt;
        pump_r   <= pump_nxt;
        heater_r <= heater_nxt;
        pct_r    <= pct_nxt;
        status_r <= status_nxt;
        if (press_we) begin
          press_r[btn] <= tick_r;
        end
      end
    end
  end

  // transaction capture, products and restoring division
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      cmd_r  <= in_cmd;
      dist_r <= in_distance_mm;
      fail_r <= in_sample_failed;
      temp_r <= in_temp_sixteenths;
    end
    if (cmd.eval) begin
      num_r  <= num_nxt;
      rem_r  <= num_nxt;
      h100_r <= 19'(h_eff) * 19'd100;
      quo_r  <= 7'd0;
    end
    if (cmd.div_step && (rem_r >= trial)) begin
      rem_r              <= rem_r - trial;
      quo_r[cmd.div_bit] <= 1'b1;
    end
  end

  // result payload shows the state after the last committed transaction
  assign pump_on            = pump_r;
  assign heater_on          = heater_r;
  assign fill_percent       = pct_r;
  assign level_setpoint     = level_r;
  assign temp_setpoint      = tlim_r;
  assign adjust_temperature = mode_r;
  assign status             = status_r;

endmodule

FILE: design/tank_level_temp_controller_core.sv
// ----------------------------------------------------------------------------
// tank_level_temp_controller_core
// A distance sample that reaches the divider passes S_EVAL, the seven steps
// of the restoring fill divider in S_DIV, and S_FIN; any other transaction
// goes from S_EVAL to S_FIN. One transaction is taken at a time; S_FIN waits
// for the output to be free. The result register frees the input side.
// Reset (synchronous, rst_n low) restores configuration and state to defaults.
// ----------------------------------------------------------------------------
module tank_level_temp_controller_core #(
  parameter int TICK_WIDTH = tltc_pkg::TICK_WIDTH_DEF
) (
  input logic        clk,
  input logic        rst_n,
  tltc_in_if.sink    in_ch,
  tltc_out_if.source out_ch,
  tltc_cfg_if.sink   cfg_ch
);

  tltc_pkg::dp_cmd_t  dp_cmd;
  tltc_pkg::dp_stat_t dp_stat;

  // configuration writes are always taken
  assign cfg_ch.ready = 1'b1;

  tltc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (dp_stat),
    .cmd       (dp_cmd)
  );

  tltc_dp #(
    .TICK_WIDTH (TICK_WIDTH)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (dp_cmd),
    .stat               (dp_stat),
    .cfg_we             (cfg_ch.valid),
    .cfg_index          (cfg_ch.index),
    .cfg_data           (cfg_ch.data),
    .in_cmd             (in_ch.cmd),
    .in_distance_mm     (in_ch.distance_mm),
    .in_sample_failed   (in_ch.sample_failed),
    .in_temp_sixteenths (in_ch.temp_sixteenths),
    .pump_on            (out_ch.pump_on),
    .heater_on          (out_ch.heater_on),
    .fill_percent       (out_ch.fill_percent),
    .level_setpoint     (out_ch.level_setpoint),
    .temp_setpoint      (out_ch.temp_setpoint),
    .adjust_temperature (out_ch.adjust_temperature),
    .status             (out_ch.status)
  );

`ifndef ASSERT_OFF
  // one transaction at a time: no acceptance right after an acceptance
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("input accepted while a transaction is in flight");

  // a commit always presents a result
  a_commit_valid: assert property (@(posedge clk) disable iff (!rst_n)
    dp_cmd.commit |=> out_ch.valid)
    else $error("commit without a valid result");

  // fill percentage stays clamped
  a_pct_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.fill_percent <= tltc_pkg::PCT_FULL))
    else $error("fill percentage above full");

  // limits stay within their bounds
  a_limit_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> ((out_ch.level_setpoint >= tltc_pkg::LEVEL_MIN) &&
                      (out_ch.level_setpoint <= tltc_pkg::LEVEL_MAX) &&
                      (out_ch.temp_setpoint >= tltc_pkg::TEMP_LMIN) &&
                      (out_ch.temp_setpoint <= tltc_pkg::TEMP_LMAX)))
    else $error("limit out of bounds");
`endif

endmodule
